FILE: hdl/ircsa_pkg.sv
// Shared types, constants and helpers for the IP route cache.
`default_nettype none

package ircsa_pkg;

    // Field and entry widths
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 4;
    localparam int CFG_W    = 11;
    localparam int AGE_W    = 8;
    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    // Set-index remainder: bits retired per divider step
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = ADDR_W / DIV_BITS;
    localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // Parameter defaults
    localparam int DEF_NUM_SETS  = 1024;
    localparam int DEF_WAYS      = 4;
    localparam int DEF_PORT_BITS = 4;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_UPDATE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic div_step;
        logic mem_read;
        logic update;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_done;
        logic div_done;
    } sts_t;

    // Saturating age increment
    function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] a);
        age_up = (a == AGE_MAX) ? a : a + 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ircsa_ctrl.sv
// Controller state machine: clearing pass, remainder, row read and update.
`default_nettype none

module ircsa_ctrl
    import ircsa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire sts_t sts,
    output cmd_t      cmd,
    output logic      busy
);

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence the clearing pass, then one word at a time, through the datapath
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // At most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.load, cmd.div_step, cmd.mem_read, cmd.update}))
        else $error("controller issued more than one command");

endmodule

`default_nettype wire

FILE: hdl/ircsa_dp.sv
// Datapath: set count register, set-index remainder, set memory and way update.
`default_nettype none

module ircsa_dp
    import ircsa_pkg::*;
#(
    parameter int NUM_SETS  = DEF_NUM_SETS,
    parameter int WAYS      = DEF_WAYS,
    parameter int PORT_BITS = DEF_PORT_BITS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    input  wire logic [ADDR_W-1:0] dst_addr,
    input  wire logic [PORT_W-1:0] in_port,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_data,
    output logic                   done,
    output logic [PORT_W-1:0]      out_port
);

    localparam int SW    = $clog2(NUM_SETS + 1);
    localparam int IW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int VW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KEY_W = ADDR_W;
    localparam int WAY_W = KEY_W + PORT_BITS + AGE_W;
    localparam int ROW_W = WAYS * WAY_W;

    logic [SW-1:0]        n_eff_reg;
    logic [IW-1:0]        clr_cnt_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [PORT_W-1:0]    port_reg;
    logic [ADDR_W-1:0]    dvd_reg;
    logic [ADDR_W-1:0]    dvd_next;
    logic [SW-1:0]        rem_reg;
    logic [SW-1:0]        rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [ROW_W-1:0]     rd_row_reg;
    logic [ROW_W-1:0]     new_row;
    logic [PORT_W-1:0]    result;
    logic                 done_reg;
    logic [PORT_W-1:0]    out_port_reg;
    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic [ROW_W-1:0]     mem_wdata;
    logic [ROW_W-1:0]     mem [NUM_SETS];

    // Clamp and hold the set count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_eff_reg <= SW'(NUM_SETS);
        end
        else if (cfg_we)
        begin
            if (cfg_data == '0)
            begin
                n_eff_reg <= SW'(1);
            end
            else if (32'(cfg_data) > 32'(NUM_SETS))
            begin
                n_eff_reg <= SW'(NUM_SETS);
            end
            else
            begin
                n_eff_reg <= SW'(cfg_data);
            end
        end
    end

    // Advance the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Retire DIV_BITS dividend bits per step by compare and subtract
    always_comb
    begin
        logic [SW:0]       t;
        logic [SW-1:0]     r;
        logic [ADDR_W-1:0] d;
        r = rem_reg;
        d = dvd_reg;
        t = '0;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            t = {r, d[ADDR_W-1]};
            d = d << 1;
            if (t >= {1'b0, n_eff_reg})
            begin
                t = t - {1'b0, n_eff_reg};
            end
            r = t[SW-1:0];
        end
        rem_next = r;
        dvd_next = d;
    end

    // Load a word and run the remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= dst_addr;
            port_reg <= in_port;
            dvd_reg  <= dst_addr;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign sts.clear_done = (clr_cnt_reg == IW'(NUM_SETS - 1));
    assign sts.div_done   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // Compare ways, age them and pick the victim on a learn
    always_comb
    begin
        logic [AGE_W-1:0]     oldest;
        logic [VW-1:0]        victim;
        logic [AGE_W-1:0]     age;
        logic [KEY_W-1:0]     key;
        logic [PORT_BITS-1:0] wport;
        new_row = rd_row_reg;
        result  = '0;
        oldest  = '0;
        victim  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            key   = rd_row_reg[w*WAY_W +: KEY_W];
            wport = rd_row_reg[w*WAY_W + KEY_W +: PORT_BITS];
            age   = rd_row_reg[w*WAY_W + KEY_W + PORT_BITS +: AGE_W];
            if (port_reg == '0)
            begin
                if (key == addr_reg)
                begin
                    result = PORT_W'(wport);
                    new_row[w*WAY_W + KEY_W + PORT_BITS +: AGE_W] = '0;
                end
                else
                begin
                    new_row[w*WAY_W + KEY_W + PORT_BITS +: AGE_W] = age_up(age);
                end
            end
            else
            begin
                if (age > oldest)
                begin
                    oldest = age;
                    victim = VW'(w);
                end
                new_row[w*WAY_W + KEY_W + PORT_BITS +: AGE_W] = age_up(age);
            end
        end
        if (port_reg != '0)
        begin
            new_row[32'(victim)*WAY_W +: WAY_W] =
                {{AGE_W{1'b0}}, PORT_BITS'(port_reg), addr_reg};
            result = PORT_W'(PORT_BITS'(port_reg));
        end
    end

    // Select the memory write: clearing sweep or row update
    assign mem_we    = cmd.clear | cmd.update;
    assign mem_waddr = cmd.clear ? clr_cnt_reg : rem_reg[IW-1:0];
    assign mem_wdata = cmd.clear ? '0 : new_row;

    // Set memory, one row per set, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_read)
        begin
            rd_row_reg <= mem[rem_reg[IW-1:0]];
        end
    end

    // Present the result word for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_port_reg <= result;
        end
    end

    assign done     = done_reg;
    assign out_port = out_port_reg;

    // Set index stays below the set count when the row is read
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_read |-> (rem_reg < n_eff_reg))
        else $error("set index out of range at row read");

    // A result word follows exactly one row update
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cmd.update))
        else $error("result strobe without a row update");

    // The row read comes right after the last remainder step
    a_read_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && sts.div_done) |=> cmd.mem_read)
        else $error("row read did not follow the remainder");

endmodule

`default_nettype wire

FILE: hdl/ip_route_cache_set_assoc.sv
// A word accepted while idle runs through the 8-step remainder unit (4 address
// bits a step), one registered row read and one row write; the result strobe is
// registered after the row write. A new word is taken only while idle.
// Reset: a clearing pass writes zero to every set row with busy high;
// configuration writes are taken throughout.
// The result strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none

module ip_route_cache_set_assoc
    import ircsa_pkg::*;
#(
    parameter int NUM_SETS  = DEF_NUM_SETS,
    parameter int WAYS      = DEF_WAYS,
    parameter int PORT_BITS = DEF_PORT_BITS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [ADDR_W-1:0] dst_addr,
    input  wire logic [PORT_W-1:0] in_port,
    output logic                   done,
    output logic [PORT_W-1:0]      out_port,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // Take configuration words at any time
    assign cfg_ready = 1'b1;

    ircsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    ircsa_dp #(
        .NUM_SETS  (NUM_SETS),
        .WAYS      (WAYS),
        .PORT_BITS (PORT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .dst_addr (dst_addr),
        .in_port  (in_port),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .done     (done),
        .out_port (out_port)
    );

endmodule

`default_nettype wire

FILE: tb/ircsa_checker.sv
`timescale 1ns / 1ps
// Route cache checker: predicts each forwarding port and compares it with the result strobe.
module ircsa_checker
    import ircsa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [ADDR_W-1:0] dst_addr,
    input  wire logic [PORT_W-1:0] in_port,
    input  wire logic              done,
    input  wire logic [PORT_W-1:0] out_port,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending_count
);

    localparam int SETS    = DEF_NUM_SETS;
    localparam int WAYS    = DEF_WAYS;
    localparam int ENTRIES = SETS * WAYS;

    // Shadow copy of the cache and its set-count register
    logic [ADDR_W-1:0] cache_key  [ENTRIES];
    logic [PORT_W-1:0] cache_port [ENTRIES];
    logic [AGE_W-1:0]  cache_age  [ENTRIES];
    logic [CFG_W-1:0]  set_count_reg;

    // Forwarding ports still owed by the block, oldest first
    logic [PORT_W-1:0] fwd_port_q [$];
    int mismatches  = 0;
    int results_got = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    // Saturating age step
    function automatic logic [AGE_W-1:0] aged(input logic [AGE_W-1:0] a);
        return (a == {AGE_W{1'b1}}) ? a : a + 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] checker: %s", $time, what);
        mismatches++;
    endtask

    // Apply one lookup or learn to the shadow cache and give the forwarding port
    task automatic apply_route_word(input logic [ADDR_W-1:0] addr,
                                    input logic [PORT_W-1:0] port,
                                    output logic [PORT_W-1:0] fwd);
        int unsigned       n;
        logic [ADDR_W-1:0] set_idx;
        int                base;
        int                victim;
        logic [AGE_W-1:0]  oldest;
        n = set_count_reg;
        if (n == 0)
            n = 1;
        if (n > SETS)
            n = SETS;
        set_idx = addr % n;
        base    = set_idx * WAYS;
        fwd     = '0;
        if (port == '0)
        begin
            // Lookup: last matching way wins, matches go young, the rest age
            for (int w = 0; w < WAYS; w++)
            begin
                if (cache_key[base + w] == addr)
                begin
                    fwd = cache_port[base + w];
                    cache_age[base + w] = '0;
                end
                else
                    cache_age[base + w] = aged(cache_age[base + w]);
            end
        end
        else
        begin
            // Learn: pick the oldest way before aging, lowest index on a tie
            victim = 0;
            oldest = '0;
            for (int w = 0; w < WAYS; w++)
            begin
                if (cache_age[base + w] > oldest)
                begin
                    oldest = cache_age[base + w];
                    victim = w;
                end
                cache_age[base + w] = aged(cache_age[base + w]);
            end
            cache_age[base + victim]  = '0;
            cache_key[base + victim]  = addr;
            cache_port[base + victim] = port;
            fwd = port;
        end
    endtask

    // Watch the channels: register write, result compare, then new word
    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [PORT_W-1:0] want;
        if (!rst_n)
        begin
            for (int e = 0; e < ENTRIES; e++)
            begin
                cache_key[e]  = '0;
                cache_port[e] = '0;
                cache_age[e]  = '0;
            end
            set_count_reg = CFG_W'(SETS);
            fwd_port_q.delete();
        end
        else
        begin
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
                set_count_reg = cfg_data;
            if (done === 1'b1)
            begin
                if (fwd_port_q.size() == 0)
                    report_mismatch($sformatf("result %0d: port %0h with no word pending",
                                              results_got, out_port));
                else
                begin
                    want = fwd_port_q.pop_front();
                    if (out_port !== want)
                        report_mismatch($sformatf("result %0d: out_port %0h, predicted %0h",
                                                  results_got, out_port, want));
                end
                results_got++;
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                apply_route_word(dst_addr, in_port, want);
                fwd_port_q.push_back(want);
            end
        end
        pending_count <= fwd_port_q.size();
        fail_count    <= mismatches;
    end

endmodule

FILE: tb/tb_ip_route_cache_set_assoc.sv
`timescale 1ns / 1ps
// Testbench top for the route cache: clock, reset, stimulus phases and the verdict.
module tb_ip_route_cache_set_assoc;
    import ircsa_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_WORDS = 120;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic [ADDR_W-1:0] dst_addr  = '0;
    logic [PORT_W-1:0] in_port   = '0;
    logic              cfg_valid = 1'b0;
    logic [CFG_W-1:0]  cfg_data  = '0;
    wire logic              busy;
    wire logic              done;
    wire logic [PORT_W-1:0] out_port;
    wire logic              cfg_ready;
    int fails;
    int pending;

    int idle_pct     = 0;
    int quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ip_route_cache_set_assoc dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .dst_addr  (dst_addr),
        .in_port   (in_port),
        .done      (done),
        .out_port  (out_port),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ircsa_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .dst_addr      (dst_addr),
        .in_port       (in_port),
        .done          (done),
        .out_port      (out_port),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fails),
        .pending_count (pending)
    );

    // Drop the run when no handshake of any kind happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start === 1'b1 && busy === 1'b0) || done === 1'b1
            || (cfg_valid === 1'b1 && cfg_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one word, idling first at the current rate, and hold it until taken
    task automatic send_word(input logic [ADDR_W-1:0] addr, input logic [PORT_W-1:0] port);
        while ($urandom_range(99) < idle_pct)
        begin
            start    <= 1'b0;
            dst_addr <= $urandom;
            in_port  <= PORT_W'($urandom);
            @(posedge clk);
        end
        start    <= 1'b1;
        dst_addr <= addr;
        in_port  <= port;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Write the set count once every result is back and the block is idle
    task automatic write_set_count(input logic [CFG_W-1:0] v);
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy !== 1'b0);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    // One phase: new set count, then lookups and learns on a small colliding pool
    task automatic run_phase(input logic [CFG_W-1:0] v, input int pct, input int count);
        logic [ADDR_W-1:0] pool [8];
        logic [ADDR_W-1:0] a;
        int unsigned       n;
        int unsigned       tgt0;
        int unsigned       tgt1;
        int                r;
        write_set_count(v);
        idle_pct = pct;
        n = (v == 0) ? 1 : ((v > DEF_NUM_SETS) ? DEF_NUM_SETS : v);
        tgt0 = $urandom_range(n - 1);
        tgt1 = $urandom_range(n - 1);
        for (int i = 0; i < 8; i++)
        begin
            a = $urandom;
            pool[i] = a - (a % n) + ((i % 2) ? tgt1 : tgt0);
        end
        pool[7] = '0;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            if (r < 10)
                send_word($urandom, PORT_W'($urandom));
            else if (r < 55)
                send_word(pool[$urandom_range(7)], '0);
            else
                send_word(pool[$urandom_range(7)], PORT_W'($urandom_range(15, 1)));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset set count
        idle_pct = 0;
        send_word(32'h0000_0000, 4'h0);     // cleared entries match address zero
        send_word(32'hFFFF_FFFF, 4'h0);     // miss
        send_word(32'hFFFF_FFFF, 4'hF);
        send_word(32'hFFFF_FFFF, 4'h0);
        send_word(32'd5,    4'h1);          // fill one set, then evict
        send_word(32'd1029, 4'h2);
        send_word(32'd2053, 4'h3);
        send_word(32'd3077, 4'h4);
        send_word(32'd4101, 4'h8);
        send_word(32'd5,    4'h0);
        send_word(32'd1029, 4'h0);
        send_word(32'd2053, 4'h0);
        send_word(32'd3077, 4'h0);
        send_word(32'd4101, 4'h0);
        send_word(32'h8000_0000, 4'hA);
        send_word(32'h8000_0000, 4'h0);
        send_word(32'h5555_5555, 4'h0);
        send_word(32'hAAAA_AAAA, 4'h0);

        // Random phases over several set counts, the field extremes among them
        run_phase(CFG_W'(1024), 0, PHASE_WORDS);
        run_phase(CFG_W'(1), 67, PHASE_WORDS);

        // Keep one way hot so the others age into saturation, then learn over them
        send_word(32'h0A00_0001, 4'h7);
        repeat (280) send_word(32'h0A00_0001, 4'h0);
        send_word(32'hC0A8_0101, 4'h9);
        send_word(32'hC0A8_0101, 4'h0);
        send_word(32'h0A00_0001, 4'h0);

        run_phase(CFG_W'(2047), 0, PHASE_WORDS);
        run_phase(CFG_W'(0), 21, PHASE_WORDS);
        run_phase(CFG_W'($urandom_range(1023, 2)), 67, PHASE_WORDS);
        run_phase(CFG_W'(3), 21, PHASE_WORDS);

        // Drain outstanding results, then give the verdict
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (15) @(posedge clk);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
